FILE: rtl/mhs_pkg.sv
// Shared types, widths and constants of the Metropolis-Hastings step unit.
// No dependencies; every other file but mhs_if imports it.
package mhs_pkg;

	localparam int COUNT_BITS = 20;
	localparam int COEF_W = COUNT_BITS + 10;
	localparam int MUL_W = (COEF_W > 34) ? COEF_W : 34;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W = COEF_W + 33;
	localparam int LN_W = 32;
	localparam int FRAC_BITS = 24;
	localparam int ADDR_W = 5;

	localparam logic [29:0] LN2_Q30 = 30'd744261118;

	localparam logic [2:0] REG_STEP = 3'd0;
	localparam logic [2:0] REG_ALPHA = 3'd1;
	localparam logic [2:0] REG_BETA = 3'd2;
	localparam logic [2:0] REG_SUBSET = 3'd3;
	localparam logic [2:0] REG_START = 3'd4;
	localparam logic [2:0] REG_SUCCESS = 3'd5;
	localparam logic [2:0] REG_TRIAL = 3'd6;

	localparam logic [15:0] STEP_RST = 16'd6554;
	localparam logic [15:0] ALPHA_RST = 16'd256;
	localparam logic [15:0] BETA_RST = 16'd256;
	localparam logic [15:0] SUBSET_RST = 16'd1;
	localparam logic [31:0] START_RST = 32'h8000_0000;

	typedef struct packed {
		logic [15:0] step_size;
		logic [15:0] prior_alpha;
		logic [15:0] prior_beta;
		logic [15:0] subset_count;
		logic [31:0] start_position;
		logic [COUNT_BITS-1:0] success_count;
		logic [COUNT_BITS-1:0] trial_count;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic signed [16:0] num;
		logic [15:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic signed [16:0] quo;
	} div_rsp_t;

endpackage

FILE: rtl/mhs_if.sv
// Request and result channel interfaces of the step unit.
// Valid/ready handshake; no dependencies.
interface mhs_in_if;
	logic valid;
	logic ready;
	logic restart;
	logic signed [15:0] normal_draw;
	logic [31:0] uniform_draw;
	modport source(output valid, restart, normal_draw, uniform_draw, input ready);
	modport sink(input valid, restart, normal_draw, uniform_draw, output ready);
endinterface

interface mhs_out_if;
	logic valid;
	logic ready;
	logic [31:0] sample;
	logic accepted;
	logic out_of_range;
	modport source(output valid, sample, accepted, out_of_range, input ready);
	modport sink(input valid, sample, accepted, out_of_range, output ready);
endinterface

FILE: rtl/mhs_regs.sv
// APB configuration registers of the step unit.
// Depends on mhs_pkg.
module mhs_regs import mhs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);
	cfg_t cfg_q;
	logic wr;

	assign wr = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_size <= STEP_RST;
			cfg_q.prior_alpha <= ALPHA_RST;
			cfg_q.prior_beta <= BETA_RST;
			cfg_q.subset_count <= SUBSET_RST;
			cfg_q.start_position <= START_RST;
			cfg_q.success_count <= '0;
			cfg_q.trial_count <= '0;
		end else if (wr) begin
			case (paddr[4:2])
				REG_STEP: cfg_q.step_size <= pwdata[15:0];
				REG_ALPHA: cfg_q.prior_alpha <= pwdata[15:0];
				REG_BETA: cfg_q.prior_beta <= pwdata[15:0];
				REG_SUBSET: cfg_q.subset_count <= pwdata[15:0];
				REG_START: cfg_q.start_position <= pwdata;
				REG_SUCCESS: cfg_q.success_count <= pwdata[COUNT_BITS-1:0];
				REG_TRIAL: cfg_q.trial_count <= pwdata[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_STEP: prdata = 32'(cfg_q.step_size);
			REG_ALPHA: prdata = 32'(cfg_q.prior_alpha);
			REG_BETA: prdata = 32'(cfg_q.prior_beta);
			REG_SUBSET: prdata = 32'(cfg_q.subset_count);
			REG_START: prdata = cfg_q.start_position;
			REG_SUCCESS: prdata = 32'(cfg_q.success_count);
			REG_TRIAL: prdata = 32'(cfg_q.trial_count);
			default: prdata = '0;
		endcase
	end
endmodule

FILE: rtl/mhs_mul.sv
// Shared signed multiplier with registered product.
// Depends on mhs_pkg.
module mhs_mul import mhs_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule

FILE: rtl/mhs_div.sv
// Bit-serial signed divider for the tempered prior coefficients.
// Truncates toward zero; a zero divisor counts as one. Depends on mhs_pkg.
module mhs_div import mhs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic        busy_q, done_q, neg_q;
	logic [4:0]  cnt_q;
	logic [15:0] num_q, rem_q, quo_q, den_q;
	logic [16:0] mag, trial, diff;
	logic        ge;

	assign mag = req.num[16] ? 17'(-req.num) : 17'(req.num);
	assign trial = {rem_q, num_q[15]};
	assign diff = trial - {1'b0, den_q};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= mag[15:0];
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= req.num[16];
			den_q <= (req.den == 16'd0) ? 16'd1 : req.den;
		end else if (busy_q) begin
			num_q <= {num_q[14:0], 1'b0};
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[14:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
endmodule

FILE: rtl/mhs_seq.sv
// Step sequencer: proposal, range check, prior coefficients, five logarithms
// and the acceptance test on one shared multiplier. Depends on mhs_pkg, mhs_if,
// mhs_mul and mhs_div.
module mhs_seq import mhs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	mhs_in_if.sink      items,
	mhs_out_if.source   results
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PROP = 4'd1;
	localparam logic [3:0] ST_RANGE = 4'd2;
	localparam logic [3:0] ST_DIVA = 4'd3;
	localparam logic [3:0] ST_DIVB = 4'd4;
	localparam logic [3:0] ST_LLOAD = 4'd5;
	localparam logic [3:0] ST_LNORM = 4'd6;
	localparam logic [3:0] ST_LSQ = 4'd7;
	localparam logic [3:0] ST_LLN2 = 4'd8;
	localparam logic [3:0] ST_LFIN = 4'd9;
	localparam logic [3:0] ST_MUL1 = 4'd10;
	localparam logic [3:0] ST_MUL2 = 4'd11;
	localparam logic [3:0] ST_SUM = 4'd12;
	localparam logic [3:0] ST_DONE = 4'd13;

	logic [3:0]  state_q;
	logic [31:0] pos_q, xp_q, u_q, v_q;
	logic signed [15:0] nd_q;
	logic [4:0]  z_q, cnt_q;
	logic [2:0]  li_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic signed [16:0] qa_q, qb_q;
	logic signed [LN_W-1:0] lnv_q [5];
	logic signed [ACC_W-1:0] acc_q;
	logic [31:0] res_sample_q;
	logic        res_acc_q, res_oor_q;
	logic        out_valid_q;
	logic [31:0] sample_q;
	logic        accepted_q, oor_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] p_q;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic signed [39:0] dx, xp;
	logic        xp_bad;
	logic [32:0] yy, arg;
	logic        sq_bit;
	logic [31:0] ynext, sq_op, arg_c;
	logic [29:0] mag;
	logic [COUNT_BITS-1:0] fails;
	logic signed [COEF_W-1:0] ca, cb;
	logic signed [LN_W-1:0] d1, d2;
	logic signed [ACC_W-1:0] tval, sum;
	logic        take, load_out;

	mhs_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(p_q));
	mhs_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	assign dx = 40'($signed(p_q[35:0]));
	assign xp = $signed({8'd0, pos_q}) + (dx <<< 4);
	assign xp_bad = xp[39] || (xp == 40'sd0) || (|xp[38:32]);

	assign yy = p_q[63:31];
	assign sq_bit = yy[32];
	assign ynext = sq_bit ? yy[32:1] : yy[31:0];
	assign sq_op = (cnt_q == 5'd0) ? v_q : ynext;
	assign mag = ((30'(z_q) + 30'd1) << FRAC_BITS) - 30'(frac_q);

	assign fails = (cfg.trial_count > cfg.success_count) ?
		(cfg.trial_count - cfg.success_count) : '0;
	assign ca = COEF_W'(qa_q) + $signed({2'b00, cfg.success_count, 8'd0});
	assign cb = COEF_W'(qb_q) + $signed({2'b00, fails, 8'd0});
	assign d1 = lnv_q[0] - lnv_q[1];
	assign d2 = lnv_q[2] - lnv_q[3];
	assign tval = ACC_W'(lnv_q[4]) <<< 8;
	assign sum = acc_q + ACC_W'(p_q);
	assign take = tval < sum;

	always_comb begin
		case (li_q)
			3'd0: arg = {1'b0, xp_q};
			3'd1: arg = {1'b0, pos_q};
			3'd2: arg = 33'h1_0000_0000 - {1'b0, xp_q};
			3'd3: arg = 33'h1_0000_0000 - {1'b0, pos_q};
			default: arg = {1'b0, u_q};
		endcase
		if (arg[32]) begin
			arg_c = 32'hFFFF_FFFF;
		end else if (arg == 33'd0) begin
			arg_c = 32'd1;
		end else begin
			arg_c = arg[31:0];
		end
	end

	always_comb begin
		case (state_q)
			ST_PROP: begin
				mul_a = MUL_W'($signed({1'b0, cfg.step_size}));
				mul_b = MUL_W'(nd_q);
			end
			ST_LSQ: begin
				mul_a = MUL_W'($signed({1'b0, sq_op}));
				mul_b = MUL_W'($signed({1'b0, sq_op}));
			end
			ST_LLN2: begin
				mul_a = MUL_W'($signed({1'b0, mag}));
				mul_b = MUL_W'($signed({1'b0, LN2_Q30}));
			end
			ST_MUL1: begin
				mul_a = MUL_W'(ca);
				mul_b = MUL_W'(d1);
			end
			ST_MUL2: begin
				mul_a = MUL_W'(cb);
				mul_b = MUL_W'(d2);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		div_req.den = cfg.subset_count;
		if (state_q == ST_DIVA) begin
			div_req.num = $signed({1'b0, cfg.prior_beta}) - 17'sd256;
			div_req.start = div_rsp.done;
		end else begin
			div_req.num = $signed({1'b0, cfg.prior_alpha}) - 17'sd256;
			div_req.start = (state_q == ST_RANGE) && !xp_bad;
		end
	end

	assign items.ready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= START_RST;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
			li_q <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (items.valid) begin
						if (items.restart) begin
							pos_q <= cfg.start_position;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_PROP;
						end
					end
				end
				ST_PROP: state_q <= ST_RANGE;
				ST_RANGE: state_q <= xp_bad ? ST_DONE : ST_DIVA;
				ST_DIVA: begin
					if (div_rsp.done) begin
						state_q <= ST_DIVB;
					end
				end
				ST_DIVB: begin
					if (div_rsp.done) begin
						li_q <= '0;
						state_q <= ST_LLOAD;
					end
				end
				ST_LLOAD: state_q <= ST_LNORM;
				ST_LNORM: begin
					if (v_q[31]) begin
						cnt_q <= '0;
						state_q <= ST_LSQ;
					end
				end
				ST_LSQ: begin
					if (cnt_q == 5'(FRAC_BITS)) begin
						state_q <= ST_LLN2;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_LLN2: state_q <= ST_LFIN;
				ST_LFIN: begin
					if (li_q == 3'd4) begin
						state_q <= ST_MUL1;
					end else begin
						li_q <= li_q + 3'd1;
						state_q <= ST_LLOAD;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_SUM;
				ST_SUM: begin
					if (take) begin
						pos_q <= xp_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				nd_q <= items.normal_draw;
				u_q <= items.uniform_draw;
				res_sample_q <= cfg.start_position;
				res_acc_q <= 1'b0;
				res_oor_q <= 1'b0;
			end
			ST_RANGE: begin
				xp_q <= xp[31:0];
				res_sample_q <= pos_q;
				res_acc_q <= 1'b0;
				res_oor_q <= xp_bad;
			end
			ST_DIVA: begin
				if (div_rsp.done) begin
					qa_q <= div_rsp.quo;
				end
			end
			ST_DIVB: begin
				if (div_rsp.done) begin
					qb_q <= div_rsp.quo;
				end
			end
			ST_LLOAD: begin
				v_q <= arg_c;
				z_q <= '0;
			end
			ST_LNORM: begin
				if (!v_q[31]) begin
					v_q <= {v_q[30:0], 1'b0};
					z_q <= z_q + 5'd1;
				end
			end
			ST_LSQ: begin
				if (cnt_q != 5'd0) begin
					frac_q <= {frac_q[FRAC_BITS-2:0], sq_bit};
				end
			end
			ST_LFIN: lnv_q[li_q] <= -$signed(p_q[30+LN_W-1:30]);
			ST_MUL2: acc_q <= ACC_W'(p_q);
			ST_SUM: begin
				res_sample_q <= take ? xp_q : pos_q;
				res_acc_q <= take;
			end
			default: ;
		endcase
		if (load_out) begin
			sample_q <= res_sample_q;
			accepted_q <= res_acc_q;
			oor_q <= res_oor_q;
		end
	end

	assign results.valid = out_valid_q;
	assign results.sample = sample_q;
	assign results.accepted = accepted_q;
	assign results.out_of_range = oor_q;

	a_oor_keeps_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RANGE && xp_bad) |=> $stable(pos_q))
		else $error("position moved on a rejected out-of-range proposal");
	a_sq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LSQ) |-> (cnt_q <= 5'(FRAC_BITS)))
		else $error("squaring count overran");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIVA || state_q == ST_DIVB))
		else $error("divider finished outside coefficient phase");
	a_accept_in_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |=> (state_q == ST_DONE))
		else $error("acceptance test did not hand over a result");
endmodule

FILE: rtl/beta_binomial_mh_step_unit.sv
// Random-walk Metropolis-Hastings step unit for a tempered Beta-binomial posterior.
// Depends on mhs_pkg, mhs_if, mhs_regs and mhs_seq.
//
// One request is taken at a time; ready is high only while the unit is idle,
// and a finished result waits in an output register so the next request can be
// taken meanwhile. A restart request goes straight to its result, and a proposal
// outside (0,1) ends right after the range check. The length of a full step
// depends on the leading-zero count of each log argument: the normaliser shifts
// one bit per cycle and the single shared multiplier performs the 24 squarings
// of each logarithm one per cycle. Configuration is to be written over APB only
// while the unit is idle; the block itself does not enforce this.
module beta_binomial_mh_step_unit import mhs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	mhs_in_if.sink            items,
	mhs_out_if.source         results
);
	cfg_t cfg;

	mhs_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	mhs_seq u_seq (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .items(items), .results(results)
	);
endmodule
